// ===== sv/qrm_pkg.sv =====
package qrm_pkg;

    // Component width of one quaternion part (Q1.15 at 16 bits)
    localparam int CW     = 16;
    // Matrix entry width, Q1.15
    localparam int OW     = 16;
    // Product width, signed
    localparam int PW     = 2 * CW;
    // Signed width of a numerator sum (four products, doubled)
    localparam int DW     = PW + 3;
    // Unsigned width of the squared norm and of |numerator| (both <= 2^(2*CW))
    localparam int NW     = PW + 1;
    // Quotient bits: floor(|D| * 2^OW / n), one per division stage
    localparam int QW     = OW + 1;
    // Matrix entries
    localparam int NENT   = 9;
    // Products x*x .. z*w
    localparam int NPROD  = 10;

    localparam int IN_TDATA_W  = 4 * CW;
    localparam int OUT_TDATA_W = NENT * OW;

    // Product slots
    typedef enum logic [3:0] {
        P_XX = 4'd0,
        P_YY = 4'd1,
        P_ZZ = 4'd2,
        P_WW = 4'd3,
        P_XY = 4'd4,
        P_XZ = 4'd5,
        P_YZ = 4'd6,
        P_XW = 4'd7,
        P_YW = 4'd8,
        P_ZW = 4'd9
    } t_prod_idx;

    typedef logic signed [PW-1:0] t_prod;
    typedef logic        [NW-1:0] t_mag;
    typedef logic        [QW-1:0] t_quot;
    typedef logic signed [OW-1:0] t_entry;

    // Round the quotient half away from zero, apply sign, saturate +1.0
    function automatic t_entry round_sat(input t_quot q, input logic neg);
        logic [QW:0]   q_inc;
        logic [QW-1:0] mag;
        t_entry        res;
        q_inc = {1'b0, q} + {{QW{1'b0}}, 1'b1};
        mag   = q_inc[QW:1];
        if (mag > QW'(1 << (OW - 1))) begin
            mag = QW'(1 << (OW - 1));
        end
        if (neg) begin
            res = t_entry'(-$signed({1'b0, mag}));
        end else if (mag > QW'((1 << (OW - 1)) - 1)) begin
            res = t_entry'((1 << (OW - 1)) - 1);
        end else begin
            res = t_entry'(mag);
        end
        return res;
    endfunction

endpackage

// ===== sv/quaternion_to_rotation_matrix.sv =====
// Quaternion to 3x3 rotation matrix. Each input transfer carries one
// quaternion (x, y, z, w) in signed Q1.15 and yields one output transfer with
// the nine entries of the rotation matrix of the normalised quaternion, each
// signed Q1.15, row-major. Every entry is 32768 * D / n with n the squared norm
// and D the usual quadratic form, rounded half away from zero; +1.0 saturates
// to 32767, -1.0 is exact. No square root is taken. A zero quaternion gives an
// all-zero matrix with the zero_norm flag set in tuser. Throughput is one
// quaternion per clock while the output side does not stall. The stages are
// a register of multipliers, one of norm and numerator sums, a restoring
// divider that resolves one quotient bit per stage for all nine entries in
// parallel, and one for rounding into the output register. Each
// stage holds its own valid bit and fills bubbles, so a stall on the output
// side only backs up as far as the first empty stage.
module quaternion_to_rotation_matrix (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [15:0] qx, [31:16] qy, [47:32] qz, [63:48] qw
    input  logic [qrm_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [15:0] m00, m01, m02, m10, m11, m12, m20, m21, [143:128] m22
    output logic [qrm_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    // [0] zero_norm
    output logic [0:0]                          o_m_tuser
);
    import qrm_pkg::*;

    // ---------------------------------------------------------------
    // Stage advance chain: a stage takes new contents when it is empty
    // or its contents move on this cycle.
    // ---------------------------------------------------------------
    logic          r_v_prod;
    logic [0:QW]   r_v_div;
    logic          r_v_out;

    logic          w_adv_out;
    logic [0:QW]   w_adv_div;
    logic          w_adv_prod;

    always_comb begin
        w_adv_out = !r_v_out || i_m_tready;
        w_adv_div[QW] = !r_v_div[QW] || w_adv_out;
        for (int s = QW - 1; s >= 0; s--) begin
            w_adv_div[s] = !r_v_div[s] || w_adv_div[s+1];
        end
        w_adv_prod = !r_v_prod || w_adv_div[0];
    end

    assign o_s_tready = w_adv_prod;

    // ---------------------------------------------------------------
    // Stage 1: the ten products
    // ---------------------------------------------------------------
    logic signed [CW-1:0] w_qx, w_qy, w_qz, w_qw;
    t_prod                r_p [NPROD];

    assign w_qx = $signed(i_s_tdata[0*CW +: CW]);
    assign w_qy = $signed(i_s_tdata[1*CW +: CW]);
    assign w_qz = $signed(i_s_tdata[2*CW +: CW]);
    assign w_qw = $signed(i_s_tdata[3*CW +: CW]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_prod <= 1'b0;
        end else if (w_adv_prod) begin
            r_v_prod <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_prod) begin
            r_p[P_XX] <= PW'(w_qx) * PW'(w_qx);
            r_p[P_YY] <= PW'(w_qy) * PW'(w_qy);
            r_p[P_ZZ] <= PW'(w_qz) * PW'(w_qz);
            r_p[P_WW] <= PW'(w_qw) * PW'(w_qw);
            r_p[P_XY] <= PW'(w_qx) * PW'(w_qy);
            r_p[P_XZ] <= PW'(w_qx) * PW'(w_qz);
            r_p[P_YZ] <= PW'(w_qy) * PW'(w_qz);
            r_p[P_XW] <= PW'(w_qx) * PW'(w_qw);
            r_p[P_YW] <= PW'(w_qy) * PW'(w_qw);
            r_p[P_ZW] <= PW'(w_qz) * PW'(w_qw);
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: squared norm, numerators, sign/magnitude split
    // ---------------------------------------------------------------
    logic signed [DW-1:0] w_xx, w_yy, w_zz, w_ww, w_xy, w_xz, w_yz, w_xw, w_yw, w_zw;
    logic signed [DW-1:0] w_d [NENT];
    logic signed [DW-1:0] w_nsum;
    logic signed [DW-1:0] w_abs [NENT];

    always_comb begin
        w_xx = DW'(r_p[P_XX]);
        w_yy = DW'(r_p[P_YY]);
        w_zz = DW'(r_p[P_ZZ]);
        w_ww = DW'(r_p[P_WW]);
        w_xy = DW'(r_p[P_XY]);
        w_xz = DW'(r_p[P_XZ]);
        w_yz = DW'(r_p[P_YZ]);
        w_xw = DW'(r_p[P_XW]);
        w_yw = DW'(r_p[P_YW]);
        w_zw = DW'(r_p[P_ZW]);

        w_nsum = w_xx + w_yy + w_zz + w_ww;
        w_d[0] = w_ww + w_xx - w_yy - w_zz;
        w_d[1] = (w_xy - w_zw) <<< 1;
        w_d[2] = (w_xz + w_yw) <<< 1;
        w_d[3] = (w_xy + w_zw) <<< 1;
        w_d[4] = w_ww - w_xx + w_yy - w_zz;
        w_d[5] = (w_yz - w_xw) <<< 1;
        w_d[6] = (w_xz - w_yw) <<< 1;
        w_d[7] = (w_yz + w_xw) <<< 1;
        w_d[8] = w_ww - w_xx - w_yy + w_zz;
        for (int j = 0; j < NENT; j++) begin
            w_abs[j] = w_d[j][DW-1] ? -w_d[j] : w_d[j];
        end
    end

    // Divider pipe: index 0 holds the dividend, index s has s quotient bits
    t_mag              r_rem  [0:QW][NENT];
    t_quot             r_q    [0:QW][NENT];
    logic [NENT-1:0]   r_neg  [0:QW];
    t_mag              r_n    [0:QW];
    logic              r_zero [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_div[0] <= 1'b0;
        end else if (w_adv_div[0]) begin
            r_v_div[0] <= r_v_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_div[0]) begin
            r_n[0]    <= w_nsum[NW-1:0];
            r_zero[0] <= (w_nsum == '0);
            for (int j = 0; j < NENT; j++) begin
                r_rem[0][j] <= w_abs[j][NW-1:0];
                r_q[0][j]   <= '0;
                r_neg[0][j] <= w_d[j][DW-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stages 3..19: restoring division, one quotient bit per stage.
    // The first step compares the dividend unshifted (|D| <= n).
    // ---------------------------------------------------------------
    for (genvar s = 1; s <= QW; s++) begin : g_div
        logic [NW:0]  w_t   [NENT];
        logic [NW:0]  w_dif [NENT];
        logic         w_ge  [NENT];
        t_mag         w_rem [NENT];
        t_quot        w_q   [NENT];

        always_comb begin
            for (int j = 0; j < NENT; j++) begin
                if (s == 1) begin
                    w_t[j] = {1'b0, r_rem[s-1][j]};
                end else begin
                    w_t[j] = {r_rem[s-1][j], 1'b0};
                end
                w_dif[j] = w_t[j] - {1'b0, r_n[s-1]};
                w_ge[j]  = (w_t[j] >= {1'b0, r_n[s-1]});
                w_rem[j] = w_ge[j] ? w_dif[j][NW-1:0] : w_t[j][NW-1:0];
                w_q[j]   = {r_q[s-1][j][QW-2:0], w_ge[j]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v_div[s] <= 1'b0;
            end else if (w_adv_div[s]) begin
                r_v_div[s] <= r_v_div[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv_div[s]) begin
                r_n[s]    <= r_n[s-1];
                r_zero[s] <= r_zero[s-1];
                r_neg[s]  <= r_neg[s-1];
                for (int j = 0; j < NENT; j++) begin
                    r_rem[s][j] <= w_rem[j];
                    r_q[s][j]   <= w_q[j];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 20: rounding, sign, saturation into the output register
    // ---------------------------------------------------------------
    t_entry r_m [NENT];
    logic   r_zn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_out <= 1'b0;
        end else if (w_adv_out) begin
            r_v_out <= r_v_div[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_out) begin
            r_zn <= r_zero[QW];
            for (int j = 0; j < NENT; j++) begin
                // zero norm: divider output is meaningless, force zeros
                r_m[j] <= r_zero[QW] ? '0 : round_sat(r_q[QW][j], r_neg[QW][j]);
            end
        end
    end

    assign o_m_tvalid = r_v_out;
    assign o_m_tuser  = r_zn;

    always_comb begin
        for (int j = 0; j < NENT; j++) begin
            o_m_tdata[j*OW +: OW] = r_m[j];
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // zero quaternion always delivers an all-zero matrix
    a_zero_matrix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("zero_norm set with non-zero matrix");

    // numerator magnitude of m00, m11 and m01 never exceeds the squared norm
    a_dividend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v_div[0] |-> ((r_rem[0][0] <= r_n[0]) && (r_rem[0][4] <= r_n[0])
                        && (r_rem[0][1] <= r_n[0])))
        else $error("dividend above norm");

    // final remainder of m00 stays below the divisor when the norm is non-zero
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v_div[QW] && !r_zero[QW]) |-> (r_rem[QW][0] < r_n[QW]))
        else $error("divider remainder out of range");

    // an accepted quaternion occupies the product stage next cycle
    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_v_prod)
        else $error("accepted transfer lost at product stage");

endmodule

// ===== bench/quaternion_to_rotation_matrix_tb.sv =====
module quaternion_to_rotation_matrix_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import qrm_pkg::*;

    // Cycles with no transfer on either side before the run is abandoned.
    // The worst case is the pipeline behind a receiver that stalls 68%
    // of the time, so the limit is far beyond any correct gap.
    localparam int STALL_LIMIT = 5000;
    // Settling time after the last expected matrix has arrived
    localparam int DRAIN_CYCLES = 40;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int MAX_LINES = 100;

    // One quaternion as carried on the input side
    typedef struct packed {
        logic [CW-1:0] qx;
        logic [CW-1:0] qy;
        logic [CW-1:0] qz;
        logic [CW-1:0] qw;
    } t_quat;

    // One matrix as expected on the output side
    typedef struct packed {
        logic [OUT_TDATA_W-1:0] mat;
        logic                   zero_norm;
    } t_matrix;

    logic                   i_clk;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // [15:0] qx, [31:16] qy, [47:32] qz, [63:48] qw
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // [15:0] m00, m01, m02, m10, m11, m12, m20, m21, [143:128] m22
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    // [0] zero_norm
    logic [0:0]             o_m_tuser;

    t_quat   quat_queue[$];    // quaternions waiting to be offered
    t_matrix matrix_queue[$];  // matrices owed by the block, oldest first

    int      send_idle_pct = 0;   // chance of the sender holding off
    int      recv_stall_pct = 0;  // chance of the receiver dropping tready
    int      fail_count = 0;
    int      quiet_cycles = 0;
    int      matrix_count = 0;

    string   entry_name[NENT] = '{"m00", "m01", "m02", "m10", "m11",
                                  "m12", "m20", "m21", "m22"};

    quaternion_to_rotation_matrix uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor: rotation matrix of the normalised quaternion.
    // Entry = 32768 * D / n, n the squared norm on the raw integers; the
    // magnitude is rounded half away from zero, then signed. +1.0 clips to
    // 32767, -1.0 stays at -32768. A zero quaternion flags zero_norm.
    // ------------------------------------------------------------------
    function automatic t_matrix rotation_of(input t_quat q);
        longint  x, y, z, w, n, d, mag, quo;
        longint  numer[NENT];
        t_entry  e;
        t_matrix r;
        x = longint'($signed(q.qx));
        y = longint'($signed(q.qy));
        z = longint'($signed(q.qz));
        w = longint'($signed(q.qw));
        r = '0;
        n = x*x + y*y + z*z + w*w;
        if (n == 0) begin
            r.zero_norm = 1'b1;
            return r;
        end
        // Diagonal terms are w^2 +/- ..., off-diagonal ones are doubled
        numer[0] = w*w + x*x - y*y - z*z;
        numer[1] = 2 * (x*y - z*w);
        numer[2] = 2 * (x*z + y*w);
        numer[3] = 2 * (x*y + z*w);
        numer[4] = w*w - x*x + y*y - z*z;
        numer[5] = 2 * (y*z - x*w);
        numer[6] = 2 * (x*z - y*w);
        numer[7] = 2 * (y*z + x*w);
        numer[8] = w*w - x*x - y*y + z*z;
        for (int i = 0; i < NENT; i++) begin
            d   = numer[i];
            mag = (d < 0) ? -d : d;
            // One guard bit below Q1.15, then round on it
            quo = (mag << (OW + 0)) / n;
            mag = (quo + 1) >>> 1;
            if (mag > 32768) mag = 32768;
            if (d < 0) begin
                e = t_entry'(-mag);
            end else begin
                if (mag > 32767) mag = 32767;
                e = t_entry'(mag);
            end
            r.mat[i*OW +: OW] = e;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        if (fail_count < MAX_LINES) begin
            $display("mismatch at matrix %0d: %s got %0d want %0d",
                     matrix_count, what, got, want);
        end
        fail_count++;
    endtask

    task automatic add_quat(input int x, input int y, input int z, input int w);
        t_quat q;
        q.qx = CW'(x);
        q.qy = CW'(y);
        q.qz = CW'(z);
        q.qw = CW'(w);
        quat_queue.push_back(q);
    endtask

    // One component drawn from a mix of full-range, small, edge and mid-range values
    function automatic int pick_part(input int style);
        int v;
        case (style)
            0: v = $urandom_range(0, 65535) - 32768;
            1: v = $urandom_range(0, 16) - 8;
            2: begin
                case ($urandom_range(0, 6))
                    0: v = -32768;
                    1: v = -32767;
                    2: v = -1;
                    3: v = 0;
                    4: v = 1;
                    5: v = 32767;
                    default: v = 16384;
                endcase
            end
            default: v = $urandom_range(0, 2047) - 1024;
        endcase
        return v;
    endfunction

    task automatic add_random_quat();
        int sel, big;
        int part[4];
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
            // zero quaternion
            part = '{0, 0, 0, 0};
        end else if (sel < 45) begin
            for (int i = 0; i < 4; i++) part[i] = pick_part(0);
        end else if (sel < 65) begin
            // tiny norms: coarse quotients and many rounding ties
            for (int i = 0; i < 4; i++) part[i] = pick_part(1);
        end else if (sel < 80) begin
            // one dominant component: entries close to +/-1.0
            big = $urandom_range(0, 3);
            for (int i = 0; i < 4; i++) begin
                part[i] = (i == big) ? pick_part(2) : pick_part(1);
            end
        end else if (sel < 90) begin
            for (int i = 0; i < 4; i++) part[i] = pick_part(2);
        end else begin
            for (int i = 0; i < 4; i++) part[i] = pick_part(3);
        end
        add_quat(part[0], part[1], part[2], part[3]);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers quaternions from quat_queue, with random hold-offs.
    // A transfer's expected matrix is queued at the edge it is accepted.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_quat q;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                matrix_queue.push_back(rotation_of(t_quat'(
                    {i_s_tdata[15:0], i_s_tdata[31:16],
                     i_s_tdata[47:32], i_s_tdata[63:48]})));
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (quat_queue.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    q = quat_queue.pop_front();
                    i_s_tdata  <= {q.qw, q.qz, q.qy, q.qx};
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each output transfer against the oldest expectation
    // and draws tready for the next cycle.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_matrix want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (matrix_queue.size() == 0) begin
                    report_mismatch("unexpected transfer, tuser", o_m_tuser, 0);
                end else begin
                    want = matrix_queue.pop_front();
                    for (int i = 0; i < NENT; i++) begin
                        if (o_m_tdata[i*OW +: OW] !== want.mat[i*OW +: OW]) begin
                            report_mismatch(entry_name[i],
                                            $signed(o_m_tdata[i*OW +: OW]),
                                            $signed(want.mat[i*OW +: OW]));
                        end
                    end
                    if (o_m_tuser[0] !== want.zero_norm) begin
                        report_mismatch("zero_norm", o_m_tuser[0], want.zero_norm);
                    end
                end
                matrix_count++;
            end
            i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: any transfer on either side restarts the count
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed corners first, then random phases under
    // different idle and stall mixes.
    // ------------------------------------------------------------------
    initial begin
        int idle_mix[4];
        int stall_mix[4];
        idle_mix  = '{0, 68, 0, 31};
        stall_mix = '{0, 0, 68, 31};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero quaternion
        add_quat(0, 0, 0, 0);
        // identity, both signs of w
        add_quat(0, 0, 0, 32767);
        add_quat(0, 0, 0, -32768);
        // half-turns about each axis: +1.0 clipping and exact -1.0
        add_quat(32767, 0, 0, 0);
        add_quat(-32768, 0, 0, 0);
        add_quat(0, -32768, 0, 0);
        add_quat(0, 0, 32767, 0);
        // all components at an extreme
        add_quat(-32768, -32768, -32768, -32768);
        add_quat(32767, 32767, 32767, 32767);
        add_quat(-32768, 32767, -32768, 32767);
        // smallest non-zero norms
        add_quat(1, 0, 0, 0);
        add_quat(0, 0, 0, -1);
        add_quat(1, 1, 0, 0);
        add_quat(1, 1, 1, 0);
        add_quat(1, -1, 1, -1);
        add_quat(3, 0, 0, 1);
        add_quat(-1, 2, -3, 4);
        // alternating bit patterns on every field
        add_quat(16'sh5555, -16'sh5556, 16'sh5555, -16'sh5556);
        add_quat(-16'sh5556, 16'sh5555, -16'sh5556, 16'sh5555);
        add_quat(16384, -16384, 16384, -16384);
        add_quat(-1, -1, -1, -1);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_mix[ph];
            recv_stall_pct = stall_mix[ph];
            for (int k = 0; k < ITEMS_PER_PHASE; k++) add_random_quat();
            while (quat_queue.size() != 0) @(posedge i_clk);
        end

        while (quat_queue.size() != 0 || i_s_tvalid || matrix_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
